### rtl/ssfs_pkg.sv
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared types and constants of the sprite-sheet frame stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssfs_pkg;

  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RandW      = 32;
  localparam int unsigned CellW      = 8;

  typedef enum logic [0:0] {
    OP_TICK     = 1'b0,
    OP_PARTICLE = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHEET_PRESENT   = 3'd0,
    REG_GRID_COLUMNS    = 3'd1,
    REG_GRID_ROWS       = 3'd2,
    REG_STEP_MODE       = 3'd3,
    REG_WRAP_MODE       = 3'd4,
    REG_THROTTLE_PERIOD = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STEP_RANDOM   = 3'd0,
    STEP_COL_UP   = 3'd1,
    STEP_COL_DOWN = 3'd2,
    STEP_ROW_DOWN = 3'd3,
    STEP_ROW_UP   = 3'd4
  } step_mode_e;

  typedef enum logic [1:0] {
    WRAP_NONE     = 2'd0,
    WRAP_FORWARD  = 2'd1,
    WRAP_BACKWARD = 2'd2,
    WRAP_CLAMP    = 2'd3
  } wrap_mode_e;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_FIN
  } back_state_e;

  typedef struct packed {
    logic             sheet_present;
    logic [CellW-1:0] grid_columns;
    logic [CellW-1:0] grid_rows;
    logic [2:0]       step_mode;
    logic [1:0]       wrap_mode;
    logic [31:0]      throttle_period;
  } cfg_t;

  typedef struct packed {
    logic             is_tick;
    logic             step;
    logic             stepping_on;
    logic [CellW-1:0] column;
    logic [CellW-1:0] row;
    logic [RandW-1:0] rand_column;
    logic [RandW-1:0] rand_row;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/ssfs_if.sv
// ----------------------------------------------------------------------------
// ssfs_if
// Request, result and configuration channels of the sprite-sheet frame stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssfs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] elapsed;
  logic [7:0]  column_in;
  logic [7:0]  row_in;
  logic [31:0] random_for_column;
  logic [31:0] random_for_row;

  modport source (
    output valid, opcode, elapsed, column_in, row_in, random_for_column, random_for_row,
    input  ready
  );
  modport sink (
    input  valid, opcode, elapsed, column_in, row_in, random_for_column, random_for_row,
    output ready
  );
endinterface

interface ssfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_out;
  logic [7:0] row_out;
  logic       stepping_on;

  modport source (
    output valid, column_out, row_out, stepping_on,
    input  ready
  );
  modport sink (
    input  valid, column_out, row_out, stepping_on,
    output ready
  );
endinterface

interface ssfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

### rtl/ssfs_front.sv
// ----------------------------------------------------------------------------
// ssfs_front
// Configuration registers, frame throttle and request classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssfs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ssfs_in_if.sink            in_i,
  ssfs_cfg_if.sink           cfg_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output ssfs_pkg::cmd_t     push_cmd_o,
  output ssfs_pkg::cfg_t     cfg_o
);
  import ssfs_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic [31:0] time_rem_q, time_rem_d;
  logic        frame_en_q, frame_en_d;
  logic        accept;
  cmd_t        cmd;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SHEET_PRESENT:   cfg_d.sheet_present   = cfg_i.data[0];
        REG_GRID_COLUMNS:    cfg_d.grid_columns    = cfg_i.data[CellW-1:0];
        REG_GRID_ROWS:       cfg_d.grid_rows       = cfg_i.data[CellW-1:0];
        REG_STEP_MODE:       cfg_d.step_mode       = cfg_i.data[2:0];
        REG_WRAP_MODE:       cfg_d.wrap_mode       = cfg_i.data[1:0];
        REG_THROTTLE_PERIOD: cfg_d.throttle_period = cfg_i.data;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    time_rem_d = time_rem_q;
    frame_en_d = frame_en_q;
    cmd        = '0;
    if (in_i.opcode == OP_TICK) begin
      if (!cfg_q.sheet_present) begin
        frame_en_d = 1'b0;
      end else if (cfg_q.throttle_period == 32'd0) begin
        frame_en_d = 1'b1;
      end else if (time_rem_q > in_i.elapsed) begin
        time_rem_d = time_rem_q - in_i.elapsed;
        frame_en_d = 1'b0;
      end else begin
        time_rem_d = cfg_q.throttle_period;
        frame_en_d = 1'b1;
      end
      cmd.is_tick     = 1'b1;
      cmd.stepping_on = frame_en_d;
    end else begin
      cmd.step        = cfg_q.sheet_present && frame_en_q;
      cmd.stepping_on = frame_en_q;
      cmd.column      = in_i.column_in;
      cmd.row         = in_i.row_in;
      cmd.rand_column = in_i.random_for_column;
      cmd.rand_row    = in_i.random_for_row;
    end
  end

  assign push_o     = accept;
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sheet_present   <= 1'b0;
      cfg_q.grid_columns    <= 8'd1;
      cfg_q.grid_rows       <= 8'd1;
      cfg_q.step_mode       <= STEP_COL_UP;
      cfg_q.wrap_mode       <= WRAP_NONE;
      cfg_q.throttle_period <= 32'd0;
      time_rem_q            <= 32'd0;
      frame_en_q            <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (accept) begin
        time_rem_q <= time_rem_d;
        frame_en_q <= frame_en_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ssfs_queue.sv
// ----------------------------------------------------------------------------
// ssfs_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssfs_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ssfs_pkg::cmd_t     push_cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output ssfs_pkg::cmd_t     head_o,
  input  wire logic          pop_i
);
  import ssfs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ssfs_back.sv
// ----------------------------------------------------------------------------
// ssfs_back
// Cell stepping, random cell selection by iterative modulo, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssfs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  ssfs_pkg::cfg_t     cfg_i,
  input  wire logic          q_valid_i,
  input  ssfs_pkg::cmd_t     q_head_i,
  output logic               pop_o,
  ssfs_out_if.source         out_o
);
  import ssfs_pkg::*;

  localparam int unsigned BitCntW = $clog2(RandW);

  function automatic logic [CellW-1:0] carry_cell(logic [CellW-1:0] v,
                                                  logic [CellW-1:0] size,
                                                  logic [1:0] wrap);
    logic [CellW-1:0] r;
    r = v;
    if (wrap == WRAP_FORWARD) begin
      r = v + 1'b1;
      if (r >= size) begin
        r = '0;
      end
    end else if (wrap == WRAP_BACKWARD) begin
      r = (v == '0) ? size - 1'b1 : v - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [2*CellW-1:0] step_cell(logic [CellW-1:0] col,
                                                   logic [CellW-1:0] row,
                                                   cfg_t cfg);
    logic [CellW-1:0] c;
    logic [CellW-1:0] r;
    logic [CellW-1:0] t;
    c = col;
    r = row;
    case (cfg.step_mode)
      STEP_COL_UP: begin
        if (cfg.grid_columns > 8'd1) begin
          c = col + 1'b1;
          if (c >= cfg.grid_columns) begin
            c = '0;
            if (cfg.wrap_mode == WRAP_CLAMP) begin
              t = row + 1'b1;
              if (t >= cfg.grid_rows) begin
                r = cfg.grid_rows - 1'b1;
                c = cfg.grid_columns - 1'b1;
              end else begin
                r = t;
              end
            end else begin
              r = carry_cell(row, cfg.grid_rows, cfg.wrap_mode);
            end
          end
        end
      end
      STEP_COL_DOWN: begin
        if (cfg.grid_columns > 8'd1) begin
          if (col == '0) begin
            c = cfg.grid_columns - 1'b1;
            r = carry_cell(row, cfg.grid_rows, cfg.wrap_mode);
          end else begin
            c = col - 1'b1;
          end
        end
      end
      STEP_ROW_DOWN: begin
        if (cfg.grid_rows > 8'd1) begin
          if (row == '0) begin
            r = cfg.grid_rows - 1'b1;
            c = carry_cell(col, cfg.grid_columns, cfg.wrap_mode);
          end else begin
            r = row - 1'b1;
          end
        end
      end
      STEP_ROW_UP: begin
        if (cfg.grid_rows > 8'd1) begin
          r = row + 1'b1;
          if (r >= cfg.grid_rows) begin
            r = '0;
            c = carry_cell(col, cfg.grid_columns, cfg.wrap_mode);
          end
        end
      end
      default: begin
        c = col;
        r = row;
      end
    endcase
    return {c, r};
  endfunction

  back_state_e        state_q, state_d;
  logic [RandW-1:0]   num_c_q, num_c_d, num_r_q, num_r_d;
  logic [CellW-1:0]   rem_c_q, rem_c_d, rem_r_q, rem_r_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic               so_q, so_d;
  logic               out_valid_q, out_valid_d;
  logic [CellW-1:0]   out_col_q, out_col_d, out_row_q, out_row_d;
  logic               out_so_q, out_so_d;
  logic               out_free;
  logic [2*CellW-1:0] stepped;
  logic [CellW:0]     try_c, try_r;

  assign out_free  = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.column_out  = out_col_q;
  assign out_o.row_out     = out_row_q;
  assign out_o.stepping_on = out_so_q;

  assign try_c = {rem_c_q, num_c_q[RandW-1]};
  assign try_r = {rem_r_q, num_r_q[RandW-1]};

  always_comb begin
    stepped = step_cell(q_head_i.column, q_head_i.row, cfg_i);
    if (!q_head_i.step) begin
      stepped = {q_head_i.column, q_head_i.row};
    end
  end

  always_comb begin
    state_d     = state_q;
    num_c_d     = num_c_q;
    num_r_d     = num_r_q;
    rem_c_d     = rem_c_q;
    rem_r_d     = rem_r_q;
    bit_d       = bit_q;
    so_d        = so_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_so_d    = out_so_q;
    pop_o       = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.step && (cfg_i.step_mode == STEP_RANDOM)) begin
            pop_o   = 1'b1;
            num_c_d = q_head_i.rand_column;
            num_r_d = q_head_i.rand_row;
            rem_c_d = '0;
            rem_r_d = '0;
            bit_d   = '0;
            so_d    = q_head_i.stepping_on;
            state_d = BACK_DIV;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_col_d   = stepped[2*CellW-1:CellW];
            out_row_d   = stepped[CellW-1:0];
            out_so_d    = q_head_i.stepping_on;
          end
        end
      end
      BACK_DIV: begin
        num_c_d = {num_c_q[RandW-2:0], 1'b0};
        num_r_d = {num_r_q[RandW-2:0], 1'b0};
        rem_c_d = (try_c >= {1'b0, cfg_i.grid_columns})
                  ? CellW'(try_c - {1'b0, cfg_i.grid_columns}) : try_c[CellW-1:0];
        rem_r_d = (try_r >= {1'b0, cfg_i.grid_rows})
                  ? CellW'(try_r - {1'b0, cfg_i.grid_rows}) : try_r[CellW-1:0];
        bit_d   = bit_q + 1'b1;
        if (bit_q == BitCntW'(RandW - 1)) begin
          state_d = BACK_FIN;
        end
      end
      BACK_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_col_d   = (cfg_i.grid_columns == '0) ? '0 : rem_c_q;
          out_row_d   = (cfg_i.grid_rows == '0) ? '0 : rem_r_q;
          out_so_d    = so_q;
          state_d     = BACK_IDLE;
        end
      end
      default: begin
        state_d = BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_c_q   <= num_c_d;
    num_r_q   <= num_r_d;
    rem_c_q   <= rem_c_d;
    rem_r_q   <= rem_r_d;
    so_q      <= so_d;
    out_col_q <= out_col_d;
    out_row_q <= out_row_d;
    out_so_q  <= out_so_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sprite_sheet_frame_stepper_unit.sv
// Ticks and stepped or held cells pass the command queue and the result register;
// random cells also run the one-bit-per-cycle modulo of the 32-bit random words.
// One non-random item per cycle while results are taken; a random cell holds off
// later items until done; a two-entry command queue decouples intake from execution.
// Reset is asynchronous and active low; it clears the queue, the throttle
// countdown and frame enable, and loads the register reset values.
// ----------------------------------------------------------------------------
// sprite_sheet_frame_stepper_unit
// Steps per-particle sprite-sheet cell indices, with a frame-time throttle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprite_sheet_frame_stepper_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ssfs_in_if.sink    in_i,
  ssfs_cfg_if.sink   cfg_i,
  ssfs_out_if.source out_o
);
  import ssfs_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;

  ssfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .cfg_o      (cfg)
  );

  ssfs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (pop)
  );

  ssfs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_head_i  (head_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

### rtl/ssfs_checker.sv
// ----------------------------------------------------------------------------
// ssfs_checker
// Port-level checks of the sprite-sheet frame stepper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssfs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_column_i,
  input wire logic [7:0] out_row_i,
  input wire logic       out_so_i
);

  logic [2:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_column_i) && $stable(out_row_i) && $stable(out_so_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result shown without a pending request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more requests in flight than the design can hold");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd4 |-> !in_ready_i)
    else $error("request taken with every slot occupied");

endmodule

bind sprite_sheet_frame_stepper_unit ssfs_checker u_ssfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_column_i (out_o.column_out),
  .out_row_i    (out_o.row_out),
  .out_so_i     (out_o.stepping_on)
);

`default_nettype wire

### sim/tb_sprite_sheet_frame_stepper_unit.sv
// ----------------------------------------------------------------------------
// tb_sprite_sheet_frame_stepper_unit
// Self-checking testbench for the sprite-sheet frame stepper. Directed requests
// cover a missing sheet, every step and wrap mode, empty and single-cell grids,
// cells outside the grid and the frame-time throttle. Random requests then run
// under changing settings and idle/stall mixes, plus one long output hold-off.
// A cell predictor runs at request acceptance, and each result is
// compared in order against its queued expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_sheet_frame_stepper_unit;
  import ssfs_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SEGMENT_ITEMS  = 30;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [2:0] STEP_HOLD_FIRST = 3'd5;
  localparam logic [2:0] STEP_HOLD_LAST  = 3'd7;

  typedef struct {
    opcode_e     op;
    logic [31:0] elapsed;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [31:0] rand_column;
    logic [31:0] rand_row;
  } request_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic       stepping_on;
  } cell_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ssfs_in_if  in_if ();
  ssfs_out_if out_if ();
  ssfs_cfg_if cfg_if ();

  sprite_sheet_frame_stepper_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  cfg_t         shadow_cfg;
  longint       time_left;
  logic         frame_on;
  cell_result_t expected_cells[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_trigger   = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  int unsigned mismatches      = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_sent      = 0;
  int unsigned particles_sent  = 0;
  int unsigned particles_moved = 0;
  int unsigned register_writes = 0;

  function automatic logic [7:0] carry_cell(input logic [7:0] v, input logic [7:0] size);
    case (shadow_cfg.wrap_mode)
      WRAP_FORWARD: begin
        v = v + 8'd1;
        if (v >= size) v = 8'd0;
      end
      WRAP_BACKWARD: v = (v == 8'd0) ? size - 8'd1 : v - 8'd1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic cell_result_t predict_cell(input request_t r);
    cell_result_t res;
    logic [7:0]   c;
    logic [7:0]   w;
    logic [7:0]   cols;
    logic [7:0]   rows;
    logic [31:0]  remainder;
    longint       left;
    c    = r.column;
    w    = r.row;
    cols = shadow_cfg.grid_columns;
    rows = shadow_cfg.grid_rows;
    if (r.op == OP_TICK) begin
      ticks_sent++;
      if (!shadow_cfg.sheet_present) begin
        frame_on = 1'b0;
      end else if (shadow_cfg.throttle_period == 32'd0) begin
        frame_on = 1'b1;
      end else begin
        left = time_left - $signed({32'd0, r.elapsed});
        if (left > 0) begin
          time_left = left;
          frame_on  = 1'b0;
        end else begin
          time_left = $signed({32'd0, shadow_cfg.throttle_period});
          frame_on  = 1'b1;
        end
      end
      c = 8'd0;
      w = 8'd0;
    end else begin
      particles_sent++;
      if (shadow_cfg.sheet_present && frame_on) begin
        particles_moved++;
        case (shadow_cfg.step_mode)
          STEP_RANDOM: begin
            remainder = (cols != 8'd0) ? r.rand_column % cols : 32'd0;
            c = remainder[7:0];
            remainder = (rows != 8'd0) ? r.rand_row % rows : 32'd0;
            w = remainder[7:0];
          end
          STEP_COL_UP: begin
            if (cols > 8'd1) begin
              c = c + 8'd1;
              if (c >= cols) begin
                c = 8'd0;
                if (shadow_cfg.wrap_mode == WRAP_CLAMP) begin
                  w = w + 8'd1;
                  if (w >= rows) begin
                    w = rows - 8'd1;
                    c = cols - 8'd1;
                  end
                end else begin
                  w = carry_cell(w, rows);
                end
              end
            end
          end
          STEP_COL_DOWN: begin
            if (cols > 8'd1) begin
              if (c == 8'd0) begin
                c = cols - 8'd1;
                w = carry_cell(w, rows);
              end else begin
                c = c - 8'd1;
              end
            end
          end
          STEP_ROW_DOWN: begin
            if (rows > 8'd1) begin
              if (w == 8'd0) begin
                w = rows - 8'd1;
                c = carry_cell(c, cols);
              end else begin
                w = w - 8'd1;
              end
            end
          end
          STEP_ROW_UP: begin
            if (rows > 8'd1) begin
              w = w + 8'd1;
              if (w >= rows) begin
                w = 8'd0;
                c = carry_cell(c, cols);
              end
            end
          end
          default: ;
        endcase
      end
    end
    res.column      = c;
    res.row         = w;
    res.stepping_on = frame_on;
    return res;
  endfunction

  function automatic request_t make_request(input opcode_e op, input logic [31:0] elapsed,
                                            input logic [7:0] column, input logic [7:0] row,
                                            input logic [31:0] rand_column,
                                            input logic [31:0] rand_row);
    request_t r;
    r.op          = op;
    r.elapsed     = elapsed;
    r.column      = column;
    r.row         = row;
    r.rand_column = rand_column;
    r.rand_row    = rand_row;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op = ($urandom_range(0, 99) < 30) ? OP_TICK : OP_PARTICLE;
    if (shadow_cfg.throttle_period == 32'd0 || $urandom_range(0, 4) == 0) begin
      r.elapsed = $urandom;
    end else begin
      r.elapsed = $urandom_range(0, shadow_cfg.throttle_period >> 1);
    end
    if ($urandom_range(0, 99) < 85) r.column = 8'($urandom_range(0, shadow_cfg.grid_columns));
    else r.column = 8'($urandom);
    if ($urandom_range(0, 99) < 85) r.row = 8'($urandom_range(0, shadow_cfg.grid_rows));
    else r.row = 8'($urandom);
    r.rand_column = $urandom;
    r.rand_row    = $urandom;
    return r;
  endfunction

  function automatic logic [7:0] random_grid_size();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return 8'($urandom);
      default: return 8'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    register_writes++;
  endtask

  task automatic configure(input logic sheet, input logic [7:0] cols, input logic [7:0] rows,
                           input logic [2:0] mode, input logic [1:0] wrap,
                           input logic [31:0] period);
    drain_results();
    write_register(REG_SHEET_PRESENT, {31'd0, sheet});
    write_register(REG_GRID_COLUMNS, {24'd0, cols});
    write_register(REG_GRID_ROWS, {24'd0, rows});
    write_register(REG_STEP_MODE, {29'd0, mode});
    write_register(REG_WRAP_MODE, {30'd0, wrap});
    write_register(REG_THROTTLE_PERIOD, period);
    cfg_if.valid <= 1'b0;
    shadow_cfg.sheet_present   = sheet;
    shadow_cfg.grid_columns    = cols;
    shadow_cfg.grid_rows       = rows;
    shadow_cfg.step_mode       = mode;
    shadow_cfg.wrap_mode       = wrap;
    shadow_cfg.throttle_period = period;
  endtask

  task automatic random_settings();
    logic [2:0]  mode;
    logic [31:0] period;
    mode = 3'($urandom_range(0, 5));
    if (mode > STEP_ROW_UP) mode = 3'($urandom_range(STEP_HOLD_FIRST, STEP_HOLD_LAST));
    case ($urandom_range(0, 3))
      0, 1: period = 32'd0;
      2: period = $urandom_range(32'h0000_1000, 32'h0004_0000);
      default: period = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                     : $urandom_range(1, 32'h0001_0000);
    endcase
    configure($urandom_range(0, 9) != 0, random_grid_size(), random_grid_size(), mode,
              2'($urandom_range(0, 3)), period);
  endtask

  // The valid stays high after acceptance; the next request or a drain decides its value.
  task automatic send_request(input request_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.opcode            <= r.op;
    in_if.elapsed           <= r.elapsed;
    in_if.column_in         <= r.column;
    in_if.row_in            <= r.row;
    in_if.random_for_column <= r.rand_column;
    in_if.random_for_row    <= r.rand_row;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_cells.push_back(predict_cell(r));
  endtask

  task automatic test_sheet_absent();
    send_request(make_request(OP_TICK, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'd0));
  endtask

  task automatic test_step_modes();
    configure(1'b1, 8'd4, 8'd3, STEP_COL_UP, WRAP_CLAMP, 32'd0);
    send_request(make_request(OP_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd3, 8'd2, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd3, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd255, 8'd7, 32'd0, 32'd0));
    configure(1'b1, 8'd0, 8'd255, STEP_RANDOM, WRAP_NONE, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd9, 8'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    configure(1'b1, 8'd5, 8'd0, STEP_COL_DOWN, WRAP_BACKWARD, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0));
    configure(1'b1, 8'd255, 8'd2, STEP_ROW_DOWN, WRAP_FORWARD, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd254, 8'd0, 32'd0, 32'd0));
    configure(1'b1, 8'd3, 8'd2, STEP_ROW_UP, WRAP_NONE, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd5, 8'd1, 32'd0, 32'd0));
    configure(1'b1, 8'd3, 8'd2, STEP_HOLD_FIRST, WRAP_FORWARD, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd1, 8'd1, 32'd0, 32'd0));
    configure(1'b1, 8'd3, 8'd2, STEP_HOLD_LAST, WRAP_FORWARD, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd2, 8'd1, 32'd0, 32'd0));
    configure(1'b1, 8'd1, 8'd1, STEP_COL_UP, WRAP_FORWARD, 32'd0);
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0));
  endtask

  task automatic test_throttle();
    configure(1'b1, 8'd4, 8'd3, STEP_COL_UP, WRAP_FORWARD, 32'h0001_0000);
    send_request(make_request(OP_TICK, 32'h0000_8000, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd1, 8'd1, 32'd0, 32'd0));
    send_request(make_request(OP_TICK, 32'h0000_8000, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd1, 8'd1, 32'd0, 32'd0));
    send_request(make_request(OP_TICK, 32'h0000_8000, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_PARTICLE, 32'd0, 8'd3, 8'd2, 32'd0, 32'd0));
    configure(1'b1, 8'd4, 8'd3, STEP_COL_UP, WRAP_FORWARD, 32'hFFFF_FFFF);
    send_request(make_request(OP_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_TICK, 32'hFFFF_FFFF, 8'd0, 8'd0, 32'd0, 32'd0));
    send_request(make_request(OP_TICK, 32'd1, 8'd0, 8'd0, 32'd0, 32'd0));
  endtask

  task automatic test_input_stall();
    configure(1'b1, 8'd6, 8'd5, STEP_ROW_UP, WRAP_FORWARD, 32'd0);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_trigger <= hold_trigger + 1;
    send_request(make_request(OP_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0));
    for (int n = 0; n < 23; n++) begin
      send_request(random_request());
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n % SEGMENT_ITEMS == 0) random_settings();
      send_request(random_request());
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_trigger != hold_seen) begin
      hold_seen    <= hold_trigger;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    cell_result_t got;
    cell_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.column      = out_if.column_out;
      got.row         = out_if.row_out;
      got.stepping_on = out_if.stepping_on;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result: col=%0d row=%0d on=%0b",
                   got.column, got.row, got.stepping_on);
        end
      end else begin
        want = expected_cells.pop_front();
        results_checked++;
        if (got.column !== want.column || got.row !== want.row ||
            got.stepping_on !== want.stepping_on) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch %0d: want col=%0d row=%0d on=%0b, got col=%0d row=%0d on=%0b",
                     results_checked, want.column, want.row, want.stepping_on,
                     got.column, got.row, got.stepping_on);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.opcode            = OP_TICK;
    in_if.elapsed           = 32'd0;
    in_if.column_in         = 8'd0;
    in_if.row_in            = 8'd0;
    in_if.random_for_column = 32'd0;
    in_if.random_for_row    = 32'd0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_SHEET_PRESENT;
    cfg_if.data             = 32'd0;
    out_if.ready            = 1'b0;

    shadow_cfg.sheet_present   = 1'b0;
    shadow_cfg.grid_columns    = 8'd1;
    shadow_cfg.grid_rows       = 8'd1;
    shadow_cfg.step_mode       = STEP_COL_UP;
    shadow_cfg.wrap_mode       = WRAP_NONE;
    shadow_cfg.throttle_period = 32'd0;
    time_left                  = 0;
    frame_on                   = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_sheet_absent();
    test_step_modes();
    test_throttle();
    test_input_stall();
    test_random_traffic(0, 0, 190);
    test_random_traffic(67, 0, 190);
    test_random_traffic(0, 67, 190);
    test_random_traffic(18, 18, 180);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d ticks and %0d particle requests (%0d moved on enabled frames).",
             ticks_sent, particles_sent, particles_moved);
    $display("Checked %0d results over %0d register writes, four idle mixes and one hold-off.",
             results_checked, register_writes);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
